FILE: src/tidr_pkg.sv
// shared constants for the transaction id remap table
// used by transaction_id_remap_table_unit
`default_nettype none
package tidr_pkg;

    localparam int DEF_ENTRIES   = 1024;
    localparam int DEF_TIME_BITS = 48;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_FIND   = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;
    localparam logic [1:0] FUNC_SWEEP  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [16:0] ID_TRIES      = 17'd65535;
    localparam logic [15:0] ID_LAST       = 16'hFFFF;
    localparam logic [15:0] ID_FIRST      = 16'd1;
    localparam logic [10:0] COUNT_MAX     = 11'd2047;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    typedef struct packed {
        logic [15:0] upstream;
        logic [15:0] client;
        logic [31:0] ip;
        logic [15:0] port;
    } tidr_client_t;

endpackage
`default_nettype wire

FILE: src/tidr_store.sv
// single-port-write, registered-read table memory for the remap entries
// no package dependencies
`default_nettype none
module tidr_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 129,
    parameter int AW    = 10
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: src/transaction_id_remap_table_unit.sv
// transaction id remap table, top level with the scan sequencer
// depends on tidr_pkg and tidr_store
`default_nettype none
// Holds ENTRIES pending requests in one table memory that a small sequencer
// walks one entry at a time (read in S_RD, then check and maybe write back
// in S_CHK). After reset the table is cleared entry by entry before s_ready
// rises. Find and remove stop at the first match; a timeout sweep always
// walks the whole table. An add scans the table once per candidate id. A
// held candidate ends its scan at the match, and the add then draws the next
// candidate; an add makes at most 65535 scans. The result sits in an output
// register; the next item is taken once the sequencer is idle again.
module transaction_id_remap_table_unit #(
    parameter int ENTRIES   = tidr_pkg::DEF_ENTRIES,
    parameter int TIME_BITS = tidr_pkg::DEF_TIME_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [31:0]          cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [1:0]           s_func,
    input  wire logic [15:0]          s_client_id,
    input  wire logic [31:0]          s_client_ip,
    input  wire logic [15:0]          s_client_port,
    input  wire logic [15:0]          s_upstream_id,
    input  wire logic [TIME_BITS-1:0] s_now_ms,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [15:0]               m_new_upstream_id,
    output logic [15:0]               m_found_client_id,
    output logic [31:0]               m_found_ip,
    output logic [15:0]               m_found_port,
    output logic [10:0]               m_expired_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CL_W  = $bits(tidr_pkg::tidr_client_t);
    localparam int WORD_W = 1 + CL_W + TIME_BITS;
    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_RD     = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_NEXTID = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]  func_reg, func_next;
    tidr_pkg::tidr_client_t req_reg, req_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [15:0] cand_reg, cand_next;
    logic [15:0] counter_reg, counter_next;
    logic [16:0] tries_reg, tries_next;
    logic        free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [31:0] timeout_reg;
    logic [1:0]  res_status_reg, res_status_next;
    logic [15:0] res_new_reg, res_new_next;
    tidr_pkg::tidr_client_t res_cl_reg, res_cl_next;
    logic [10:0] count_reg, count_next;

    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [15:0] m_new_reg;
    tidr_pkg::tidr_client_t m_cl_reg;
    logic [10:0] m_count_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;

    logic                   e_valid;
    tidr_pkg::tidr_client_t e_cl;
    logic [TIME_BITS-1:0]   e_created;
    logic [TIME_BITS-1:0]   age;
    logic                   expired;
    logic                   last;
    logic                   out_free;
    logic                   accept;

    tidr_store #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W),
        .AW    (IDX_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign e_valid   = rd_data[WORD_W-1];
    assign e_cl      = rd_data[WORD_W-2 -: CL_W];
    assign e_created = rd_data[TIME_BITS-1:0];
    assign age       = now_reg - e_created;
    assign expired   = CMP_W'(age) >= CMP_W'(timeout_reg);
    assign last      = (idx_reg == LAST_IDX);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    function automatic logic [15:0] bump(input logic [15:0] c);
        bump = (c == tidr_pkg::ID_LAST) ? tidr_pkg::ID_FIRST : c + 16'd1;
    endfunction

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        func_next       = func_reg;
        req_next        = req_reg;
        now_next        = now_reg;
        cand_next       = cand_reg;
        counter_next    = counter_reg;
        tries_next      = tries_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_new_next    = res_new_reg;
        res_cl_next     = res_cl_reg;
        count_next      = count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {1'b0, rd_data[WORD_W-2:0]};

        unique case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_data = '0;
                if (last) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    func_next           = s_func;
                    req_next.upstream   = s_upstream_id;
                    req_next.client     = s_client_id;
                    req_next.ip         = s_client_ip;
                    req_next.port       = s_client_port;
                    now_next            = s_now_ms;
                    idx_next            = '0;
                    res_status_next     = tidr_pkg::ST_OK;
                    res_new_next        = '0;
                    res_cl_next         = '0;
                    count_next          = '0;
                    free_found_next     = 1'b0;
                    // for an add, the counter moves as soon as a candidate is drawn
                    cand_next           = counter_reg;
                    tries_next          = 17'd1;
                    if (s_func == tidr_pkg::FUNC_ADD) begin
                        counter_next = bump(counter_reg);
                    end
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                state_next = S_RD;
                idx_next   = idx_reg + IDX_W'(1);
                unique case (func_reg)
                    tidr_pkg::FUNC_ADD: begin
                        if (!e_valid && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                        if (e_valid && e_cl.upstream == cand_reg) begin
                            state_next = S_NEXTID;
                        end else if (last) begin
                            state_next = S_OUT;
                            if (free_found_reg || !e_valid) begin
                                wr_en   = 1'b1;
                                wr_addr = free_found_reg ? free_idx_reg : idx_reg;
                                wr_data = {1'b1, cand_reg, req_reg.client, req_reg.ip,
                                           req_reg.port, now_reg};
                                res_new_next = cand_reg;
                            end else begin
                                res_status_next = tidr_pkg::ST_FULL;
                            end
                        end
                    end
                    tidr_pkg::FUNC_FIND, tidr_pkg::FUNC_REMOVE: begin
                        if (e_valid && e_cl.upstream == req_reg.upstream) begin
                            state_next = S_OUT;
                            if (func_reg == tidr_pkg::FUNC_FIND) begin
                                res_cl_next = e_cl;
                                res_cl_next.upstream = '0;
                            end else begin
                                wr_en = 1'b1;
                            end
                        end else if (last) begin
                            state_next      = S_OUT;
                            res_status_next = tidr_pkg::ST_NOTFOUND;
                        end
                    end
                    tidr_pkg::FUNC_SWEEP: begin
                        if (e_valid && expired) begin
                            wr_en = 1'b1;
                            if (count_reg != tidr_pkg::COUNT_MAX) begin
                                count_next = count_reg + 11'd1;
                            end
                        end
                        if (last) begin
                            state_next = S_OUT;
                        end
                    end
                    default: ;
                endcase
            end
            S_NEXTID: begin
                if (tries_reg == tidr_pkg::ID_TRIES) begin
                    res_status_next = tidr_pkg::ST_FULL;
                    state_next      = S_OUT;
                end else begin
                    cand_next       = counter_reg;
                    counter_next    = bump(counter_reg);
                    tries_next      = tries_reg + 17'd1;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    state_next      = S_RD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            idx_reg     <= '0;
            counter_reg <= tidr_pkg::ID_FIRST;
            timeout_reg <= tidr_pkg::TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            counter_reg <= counter_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        req_reg        <= req_next;
        now_reg        <= now_next;
        cand_reg       <= cand_next;
        tries_reg      <= tries_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_new_reg    <= res_new_next;
        res_cl_reg     <= res_cl_next;
        count_reg      <= count_next;
        if (state_reg == S_OUT && out_free) begin
            m_status_reg <= res_status_reg;
            m_new_reg    <= res_new_reg;
            m_cl_reg     <= res_cl_reg;
            m_count_reg  <= count_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_new_upstream_id = m_new_reg;
    assign m_found_client_id = m_cl_reg.client;
    assign m_found_ip        = m_cl_reg.ip;
    assign m_found_port      = m_cl_reg.port;
    assign m_expired_count   = m_count_reg;

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("item accepted during table clear");

    a_counter_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        counter_reg != 16'd0)
        else $error("id counter reached zero");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == tidr_pkg::ST_OK || m_status == tidr_pkg::ST_NOTFOUND
                     || m_status == tidr_pkg::ST_FULL))
        else $error("bad status code");

    a_new_id_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_new_upstream_id != 16'd0) |-> (m_status == tidr_pkg::ST_OK))
        else $error("new id given with failing status");

endmodule
`default_nettype wire
